### rtl/core/psat_pkg.sv
package psat_pkg;

   localparam int unsigned AddrWidth     = 48;
   localparam int unsigned RssiWidth     = 8;
   localparam int unsigned TypeWidth     = 2;
   localparam int unsigned SubtypeWidth  = 4;
   localparam int unsigned StatusWidth   = 3;
   localparam int unsigned IndexWidth    = 8;
   localparam int unsigned CountWidth    = 9;
   localparam int unsigned CsrIndexWidth = 1;
   localparam int unsigned CsrDataWidth  = 8;

   localparam logic [StatusWidth-1:0] StIgnored = 3'd0;
   localparam logic [StatusWidth-1:0] StNew     = 3'd1;
   localparam logic [StatusWidth-1:0] StNear    = 3'd2;
   localparam logic [StatusWidth-1:0] StQuiet   = 3'd3;
   localparam logic [StatusWidth-1:0] StDropped = 3'd4;

   localparam logic [CsrIndexWidth-1:0] CsrRssiThreshold = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CsrReportNearby  = 1'd1;

   localparam logic signed [RssiWidth-1:0] RssiThresholdReset = -8'sd40;
   localparam logic                        ReportNearbyReset  = 1'b1;

   localparam logic [TypeWidth-1:0]    FrameTypeMgmt   = 2'd0;
   localparam logic [SubtypeWidth-1:0] SubtypeProbeReq = 4'd4;

   typedef struct packed {
      logic                 is_probe;
      logic                 near;
      logic [AddrWidth-1:0] addr;
   } item_type;

endpackage

### rtl/core/psat_if.sv
interface psat_req_if;
   import psat_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [TypeWidth-1:0]        frame_type;
   logic [SubtypeWidth-1:0]     frame_subtype;
   logic [AddrWidth-1:0]        source_address;
   logic signed [RssiWidth-1:0] signal_strength;

   modport source (output valid, frame_type, frame_subtype, source_address, signal_strength,
                   input ready);
   modport sink (input valid, frame_type, frame_subtype, source_address, signal_strength,
                 output ready);
endinterface

interface psat_rsp_if;
   import psat_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [StatusWidth-1:0]  status;
   logic [IndexWidth-1:0]   entry_index;
   logic [CountWidth-1:0]   entry_count;

   modport source (output valid, status, entry_index, entry_count, input ready);
   modport sink (input valid, status, entry_index, entry_count, output ready);
endinterface

### rtl/core/probe_source_address_tracker.sv
// Channel   Direction  Contents
// req_chan  in         frame_type, frame_subtype, source_address, signal_strength
// rsp_chan  out        status, entry_index, entry_count
// csr_*     in         write enable, register index, write data
//
// A request that is not a probe request skips the table search and goes straight to the result.
// A probe request reads the stored addresses in turn, one table read per cycle; a hit in slot i
// ends the search, and an address that is not found is added, or dropped if the table is full.
// Reset is synchronous; the table itself is not cleared, only the fill count.
// A two-entry queue keeps requests flowing in while a search runs or a result waits.
module probe_source_address_tracker #(
   parameter int unsigned TABLE_DEPTH = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   psat_req_if.sink                             req_chan,
   psat_rsp_if.source                           rsp_chan,
   input  logic                                 csr_write_enable,
   input  logic [psat_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [psat_pkg::CsrDataWidth-1:0]    csr_write_data
);
   import psat_pkg::*;

   logic     q_valid;
   logic     q_ready;
   item_type q_item;

   psat_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .q_valid          (q_valid),
      .q_ready          (q_ready),
      .q_item           (q_item)
   );

   psat_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_item   (q_item),
      .rsp_chan (rsp_chan)
   );

endmodule

### rtl/core/psat_ram.sv
module psat_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 256
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### rtl/core/psat_front.sv
module psat_front (
   input  logic                                     clock,
   input  logic                                     reset,
   psat_req_if.sink                                 req_chan,
   input  logic                                     csr_write_enable,
   input  logic [psat_pkg::CsrIndexWidth-1:0]       csr_index,
   input  logic [psat_pkg::CsrDataWidth-1:0]        csr_write_data,
   output logic                                     q_valid,
   input  logic                                     q_ready,
   output psat_pkg::item_type                       q_item
);
   import psat_pkg::*;

   localparam int unsigned QueueDepth = 2;

   logic signed [RssiWidth-1:0] thr_ff, thr_in;
   logic                        near_en_ff, near_en_in;
   item_type                    slot_ff [QueueDepth];
   item_type                    item_in;
   logic                        wr_ptr_ff, wr_ptr_in;
   logic                        rd_ptr_ff, rd_ptr_in;
   logic [1:0]                  count_ff, count_in;
   logic                        push;
   logic                        pop;

   assign req_chan.ready = (count_ff != 2'(QueueDepth));
   assign push           = req_chan.valid && req_chan.ready;
   assign q_valid        = (count_ff != 2'd0);
   assign pop            = q_valid && q_ready;
   assign q_item         = slot_ff[rd_ptr_ff];

   always_comb begin
      thr_in     = thr_ff;
      near_en_in = near_en_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CsrRssiThreshold: thr_in     = signed'(csr_write_data[RssiWidth-1:0]);
            CsrReportNearby:  near_en_in = csr_write_data[0];
            default: ;
         endcase
      end

      item_in.is_probe = (req_chan.frame_type == FrameTypeMgmt)
                         && (req_chan.frame_subtype == SubtypeProbeReq);
      item_in.near     = near_en_ff && (req_chan.signal_strength > thr_ff);
      item_in.addr     = req_chan.source_address;

      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff     <= RssiThresholdReset;
         near_en_ff <= ReportNearbyReset;
         wr_ptr_ff  <= 1'b0;
         rd_ptr_ff  <= 1'b0;
         count_ff   <= 2'd0;
      end else begin
         thr_ff     <= thr_in;
         near_en_ff <= near_en_in;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         count_ff   <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

`ifndef ASSERT_OFF
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QueueDepth))
      else $error("request queue holds more entries than it has slots");

   a_queue_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("queue occupancy did not follow an accepted request");
`endif

endmodule

### rtl/core/psat_back.sv
module psat_back #(
   parameter int unsigned TABLE_DEPTH = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_ready,
   input  psat_pkg::item_type  q_item,
   psat_rsp_if.source          rsp_chan
);
   import psat_pkg::*;

   localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_EMIT
   } state_type;

   state_type               state_ff, state_in;
   item_type                item_ff, item_in;
   logic [CntW-1:0]         fill_ff, fill_in;
   logic [CntW-1:0]         issue_ff, issue_in;
   logic                    pend_ff, pend_in;
   logic [IdxW-1:0]         cmp_idx_ff, cmp_idx_in;
   logic [StatusWidth-1:0]  res_status_ff, res_status_in;
   logic [IndexWidth-1:0]   res_index_ff, res_index_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [StatusWidth-1:0]  rsp_status_ff, rsp_status_in;
   logic [IndexWidth-1:0]   rsp_index_ff, rsp_index_in;
   logic [CountWidth-1:0]   rsp_count_ff, rsp_count_in;

   logic                    rd_en;
   logic [AddrWidth-1:0]    rd_data;
   logic                    ram_we;
   logic                    hit;
   logic                    full;
   logic                    out_free;

   assign rd_en    = (state_ff == S_SCAN) && (issue_ff < fill_ff);
   assign hit      = pend_ff && (rd_data == item_ff.addr);
   assign full     = (fill_ff == CntW'(TABLE_DEPTH));
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign ram_we   = (state_ff == S_SCAN) && !hit && !rd_en && !pend_ff && !full;
   assign q_ready  = (state_ff == S_IDLE);

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.entry_index = rsp_index_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

   psat_ram #(
      .WIDTH (AddrWidth),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (fill_ff[IdxW-1:0]),
      .wr_data (item_ff.addr),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[IdxW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      fill_in       = fill_ff;
      issue_in      = issue_ff;
      pend_in       = pend_ff;
      cmp_idx_in    = cmp_idx_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               item_in  = q_item;
               issue_in = '0;
               pend_in  = 1'b0;
               if (q_item.is_probe) begin
                  state_in = S_SCAN;
               end else begin
                  res_status_in = StIgnored;
                  res_index_in  = '0;
                  state_in      = S_EMIT;
               end
            end
         end
         S_SCAN: begin
            pend_in    = rd_en;
            cmp_idx_in = issue_ff[IdxW-1:0];
            issue_in   = issue_ff + CntW'(rd_en);
            priority if (hit) begin
               res_status_in = item_ff.near ? StNear : StQuiet;
               res_index_in  = IndexWidth'(cmp_idx_ff);
               state_in      = S_EMIT;
            end else if (!rd_en && !pend_ff) begin
               if (full) begin
                  res_status_in = StDropped;
                  res_index_in  = '0;
               end else begin
                  res_status_in = StNew;
                  res_index_in  = IndexWidth'(fill_ff);
                  fill_in       = fill_ff + CntW'(1);
               end
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_ff;
               rsp_count_in  = CountWidth'(fill_ff);
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff       <= item_in;
      issue_ff      <= issue_in;
      cmp_idx_ff    <= cmp_idx_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
   end

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CntW'(TABLE_DEPTH))
      else $error("fill count exceeds the table depth");

   a_write_counts: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> (fill_ff == $past(fill_ff) + CntW'(1)))
      else $error("table write did not advance the fill count");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (issue_ff < fill_ff))
      else $error("search read beyond the filled part of the table");

   a_new_after_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !(rsp_valid_ff && !rsp_chan.ready) && res_status_ff == StNew)
      |-> (fill_ff != '0))
      else $error("new address reported with an empty table");
`endif

endmodule
